FILE: design/topk_precision_recall_counter_top_macros.svh
// Assertion helpers for the top-k precision/recall counter
`ifndef TOPK_PRECISION_RECALL_COUNTER_TOP_MACROS_SVH
`define TOPK_PRECISION_RECALL_COUNTER_TOP_MACROS_SVH
// implication checked every clock outside reset
`define TPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/tpr_pkg.sv
package tpr_pkg;
	typedef enum logic [1:0] {
		CMD_LABEL = 2'd0,
		CMD_SCORE = 2'd1,
		CMD_EOR   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// one word carried from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] id;
		logic [31:0] value;
	} item_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_MATCH,
		ST_LREAD,
		ST_FINISH
	} state_t;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [15:0] SAT16 = 16'hFFFF;
endpackage

FILE: design/tpr_fifo.sv
// Small word queue between front and back
module tpr_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  tpr_pkg::item_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output tpr_pkg::item_t  rd_data,
	output logic            empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	tpr_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !empty)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end
endmodule

FILE: design/tpr_back.sv
// Back end: keeps the top-k list, the label store and the totals
module tpr_back #(
	parameter int TOP_MAX   = 64,
	parameter int LABEL_MAX = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [6:0]      top_count,
	input  logic            in_valid,
	input  tpr_pkg::item_t  in_item,
	output logic            in_take,
	output logic            idle,
	output logic            res_valid,
	input  logic            res_take,
	output logic [6:0]      row_tp,
	output logic [6:0]      row_pred,
	output logic [15:0]     row_pos,
	output logic [31:0]     tot_tp,
	output logic [31:0]     tot_pred,
	output logic [31:0]     tot_pos,
	output logic            ovf
);
	localparam int TW = $clog2(TOP_MAX + 1);
	localparam int LW = $clog2(LABEL_MAX + 1);
	localparam int TA = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
	localparam int LA = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	// kept list and label store as memories
	logic [31:0] kid_mem [TOP_MAX];
	logic [31:0] ksc_mem [TOP_MAX];
	logic [31:0] lid_mem [LABEL_MAX];
	logic        lpos_mem [LABEL_MAX];

	tpr_pkg::state_t st_q, st_d;
	logic [TW-1:0] kcnt_q, i_q, low_q;
	logic [LW-1:0] lcnt_q, j_q;
	logic [15:0]   rpos_q;
	logic          ovf_q;
	logic [31:0]   sum_tp_q, sum_pred_q, sum_pos_q;
	logic [6:0]    tp_q;
	logic [31:0]   cur_id_q, cur_sc_q, low_sc_q;
	logic [31:0]   kid_rd_q, ksc_rd_q, lid_rd_q;
	logic          lpos_rd_q;
	logic          rd_ok_q;
	logic          res_q;
	logic [6:0]    out_tp_q, out_pred_q;
	logic [15:0]   out_pos_q;
	logic          out_ovf_q;
	logic [31:0]   out_sum_tp_q, out_sum_pred_q, out_sum_pos_q;

	logic [TW-1:0] klim;
	logic          take;
	logic          is_pos;
	logic          low_hit;
	logic [31:0]   low_sc_now;
	logic          fin_go;
	logic [31:0]   sum_tp_d, sum_pred_d, sum_pos_d;

	assign klim = (int'(top_count) > TOP_MAX) ? TW'(TOP_MAX) : TW'(top_count);
	assign take = in_valid && (st_q == tpr_pkg::ST_IDLE);
	assign in_take = take;
	assign is_pos = !in_item.value[31] && (in_item.value != '0);

	// running minimum, including the word read this cycle
	assign low_hit = rd_ok_q && (i_q == TW'(1) || $signed(ksc_rd_q) <= $signed(low_sc_q));
	assign low_sc_now = low_hit ? ksc_rd_q : low_sc_q;

	// row result moves to the output register once that is free
	assign fin_go = (st_q == tpr_pkg::ST_FINISH) && (!res_q || res_take);

	// saturating totals after this row
	assign sum_tp_d = ({1'b0, sum_tp_q} + 33'(tp_q)) > 33'(tpr_pkg::SAT32)
		? tpr_pkg::SAT32 : sum_tp_q + 32'(tp_q);
	assign sum_pred_d = ({1'b0, sum_pred_q} + 33'(kcnt_q)) > 33'(tpr_pkg::SAT32)
		? tpr_pkg::SAT32 : sum_pred_q + 32'(kcnt_q);
	assign sum_pos_d = ({1'b0, sum_pos_q} + 33'(rpos_q)) > 33'(tpr_pkg::SAT32)
		? tpr_pkg::SAT32 : sum_pos_q + 32'(rpos_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			tpr_pkg::ST_IDLE: begin
				if (take && in_item.cmd == tpr_pkg::CMD_SCORE &&
				    kcnt_q >= klim && kcnt_q != '0)
					st_d = tpr_pkg::ST_SCAN;
				else if (take && in_item.cmd == tpr_pkg::CMD_EOR)
					st_d = (kcnt_q == '0 || lcnt_q == '0) ? tpr_pkg::ST_FINISH
						: tpr_pkg::ST_MATCH;
			end
			tpr_pkg::ST_SCAN:
				if (i_q == kcnt_q)
					st_d = ($signed(cur_sc_q) > $signed(low_sc_now)) ? tpr_pkg::ST_SHIFT
						: tpr_pkg::ST_IDLE;
			tpr_pkg::ST_SHIFT:
				if (i_q == kcnt_q && !rd_ok_q) st_d = tpr_pkg::ST_IDLE;
			tpr_pkg::ST_MATCH:
				if (i_q == kcnt_q) st_d = tpr_pkg::ST_FINISH;
			tpr_pkg::ST_LREAD: st_d = tpr_pkg::ST_MATCH;
			tpr_pkg::ST_FINISH:
				if (!res_q || res_take) st_d = tpr_pkg::ST_IDLE;
			default: st_d = tpr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle      = (st_q == tpr_pkg::ST_IDLE);
		res_valid = res_q;
		row_tp    = out_tp_q;
		row_pred  = out_pred_q;
		row_pos   = out_pos_q;
		tot_tp    = out_sum_tp_q;
		tot_pred  = out_sum_pred_q;
		tot_pos   = out_sum_pos_q;
		ovf       = out_ovf_q;
	end

	// memory ports: one registered read each, writes from the sequencer
	always_ff @(posedge clk) begin
		kid_rd_q  <= kid_mem[i_q[TA-1:0]];
		ksc_rd_q  <= ksc_mem[i_q[TA-1:0]];
		lid_rd_q  <= lid_mem[j_q[LA-1:0]];
		lpos_rd_q <= lpos_mem[j_q[LA-1:0]];
		if (take && in_item.cmd == tpr_pkg::CMD_SCORE && kcnt_q < klim) begin
			kid_mem[kcnt_q[TA-1:0]] <= in_item.id;
			ksc_mem[kcnt_q[TA-1:0]] <= in_item.value;
		end else if (st_q == tpr_pkg::ST_SHIFT && rd_ok_q) begin
			// move entry i-1 down one slot; last slot takes the new word
			kid_mem[TA'(i_q - 2'd2)] <= kid_rd_q;
			ksc_mem[TA'(i_q - 2'd2)] <= ksc_rd_q;
		end else if (st_q == tpr_pkg::ST_SHIFT && i_q == kcnt_q) begin
			kid_mem[TA'(kcnt_q - 1'b1)] <= cur_id_q;
			ksc_mem[TA'(kcnt_q - 1'b1)] <= cur_sc_q;
		end
		if (take && in_item.cmd == tpr_pkg::CMD_LABEL && lcnt_q < LW'(LABEL_MAX)) begin
			lid_mem[lcnt_q[LA-1:0]]  <= in_item.id;
			lpos_mem[lcnt_q[LA-1:0]] <= is_pos;
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tpr_pkg::ST_IDLE;
			kcnt_q <= '0; lcnt_q <= '0; rpos_q <= '0; ovf_q <= 1'b0;
			sum_tp_q <= '0; sum_pred_q <= '0; sum_pos_q <= '0;
			i_q <= '0; j_q <= '0; low_q <= '0; tp_q <= '0;
			rd_ok_q <= 1'b0; res_q <= 1'b0;
			cur_id_q <= '0; cur_sc_q <= '0; low_sc_q <= '0;
			out_tp_q <= '0; out_pred_q <= '0; out_pos_q <= '0; out_ovf_q <= 1'b0;
			out_sum_tp_q <= '0; out_sum_pred_q <= '0; out_sum_pos_q <= '0;
		end else begin
			st_q <= st_d;
			// result register: loaded when a row finishes, freed when popped
			if (fin_go) res_q <= 1'b1;
			else if (res_take) res_q <= 1'b0;
			case (st_q)
				tpr_pkg::ST_IDLE: begin
					i_q <= '0; j_q <= '0; rd_ok_q <= 1'b0;
					if (take) begin
						cur_id_q <= in_item.id;
						cur_sc_q <= in_item.value;
						case (in_item.cmd)
							tpr_pkg::CMD_LABEL: begin
								if (is_pos && rpos_q != tpr_pkg::SAT16)
									rpos_q <= rpos_q + 1'b1;
								if (lcnt_q < LW'(LABEL_MAX)) lcnt_q <= lcnt_q + 1'b1;
								else ovf_q <= 1'b1;
							end
							tpr_pkg::CMD_SCORE:
								if (kcnt_q < klim) kcnt_q <= kcnt_q + 1'b1;
							tpr_pkg::CMD_CLEAR: begin
								sum_tp_q <= '0; sum_pred_q <= '0; sum_pos_q <= '0;
							end
							default: ;
						endcase
					end
				end
				tpr_pkg::ST_SCAN: begin
					// min search, later ties win
					rd_ok_q <= (i_q != kcnt_q);
					if (low_hit) begin
						low_sc_q <= ksc_rd_q;
						low_q    <= i_q - 1'b1;
					end
					if (i_q != kcnt_q) i_q <= i_q + 1'b1;
					else if (low_hit) i_q <= i_q;
					else i_q <= low_q + 1'b1;
				end
				tpr_pkg::ST_SHIFT: begin
					// read i, write it at i-1 next cycle
					if (i_q != kcnt_q) i_q <= i_q + 1'b1;
					rd_ok_q <= (i_q != kcnt_q);
				end
				tpr_pkg::ST_MATCH: begin
					// for kept entry i walk labels j until first id hit
					if (rd_ok_q && lid_rd_q == kid_rd_q) begin
						if (lpos_rd_q) tp_q <= tp_q + 1'b1;
						i_q <= i_q + 1'b1; j_q <= '0; rd_ok_q <= 1'b0;
					end else if (rd_ok_q && j_q == lcnt_q - 1'b1) begin
						i_q <= i_q + 1'b1; j_q <= '0; rd_ok_q <= 1'b0;
					end else if (rd_ok_q) begin
						j_q <= j_q + 1'b1; rd_ok_q <= 1'b0;
					end else begin
						rd_ok_q <= 1'b1;
					end
				end
				tpr_pkg::ST_FINISH: begin
					// snapshot the row and totals, then start a fresh row
					if (!res_q || res_take) begin
						sum_tp_q       <= sum_tp_d;
						sum_pred_q     <= sum_pred_d;
						sum_pos_q      <= sum_pos_d;
						out_sum_tp_q   <= sum_tp_d;
						out_sum_pred_q <= sum_pred_d;
						out_sum_pos_q  <= sum_pos_d;
						out_tp_q       <= tp_q;
						out_pred_q     <= 7'(kcnt_q);
						out_pos_q      <= rpos_q;
						out_ovf_q      <= ovf_q;
						kcnt_q <= '0; lcnt_q <= '0; rpos_q <= '0; ovf_q <= 1'b0;
						tp_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: design/topk_precision_recall_counter_top.sv
// Flow: each word waits in the front queue; label, score-append and clear words
// then pass straight through the back end; an evicting score runs a minimum scan
// and then a shift. End of row compares kept ids with labels (at most kept x labels
// compares), then registers the result. Throughput: one word per cycle at best,
// and less while an evicting score or an end of row holds the back end.
// Reset: asynchronous, clears counts, totals and k=1; stores stay unwritten.
module topk_precision_recall_counter_top #(
	parameter int TOP_MAX   = 64,
	parameter int LABEL_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [31:0] item_id,
	input  logic signed [31:0] item_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  row_true_positives,
	output logic [6:0]  row_predictions,
	output logic [15:0] row_positive_labels,
	output logic [31:0] total_true_positives,
	output logic [31:0] total_predictions,
	output logic [31:0] total_positive_labels,
	output logic        label_overflow
);
	logic [6:0] k_q;
	tpr_pkg::item_t in_w, q_w;
	logic q_empty, take, res_v, back_idle;

	// k only changes while no word is queued or being worked on
	assign cfg_ready = q_empty && back_idle;
	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= 7'd1;
		else if (cfg_valid && cfg_ready) k_q <= cfg_data;
	end

	// front: classify and queue
	assign in_w.cmd   = tpr_pkg::cmd_t'(command);
	assign in_w.id    = item_id;
	assign in_w.value = item_value;

	tpr_fifo #(.DEPTH(2)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data(in_w), .full(full),
		.rd_en(take), .rd_data(q_w), .empty(q_empty)
	);

	tpr_back #(.TOP_MAX(TOP_MAX), .LABEL_MAX(LABEL_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .top_count(k_q),
		.in_valid(!q_empty), .in_item(q_w), .in_take(take), .idle(back_idle),
		.res_valid(res_v), .res_take(pop),
		.row_tp(row_true_positives), .row_pred(row_predictions),
		.row_pos(row_positive_labels), .tot_tp(total_true_positives),
		.tot_pred(total_predictions), .tot_pos(total_positive_labels),
		.ovf(label_overflow)
	);
	assign empty = !res_v;
endmodule

FILE: design/tpr_checker.sv
`include "topk_precision_recall_counter_top_macros.svh"
// Port-level checks
module tpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [6:0]  row_true_positives,
	input logic [6:0]  row_predictions,
	input logic [31:0] total_predictions
);
	`TPR_ASSERT_IMP(a_tp_le_pred, clk, arst_n, !empty, row_true_positives <= row_predictions, "tp above predictions")
	`TPR_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty, "result dropped")
	`TPR_ASSERT_IMP(a_pred_le_tot, clk, arst_n, !empty, 32'(row_predictions) <= total_predictions, "total below row")
endmodule

bind topk_precision_recall_counter_top tpr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.row_true_positives(row_true_positives), .row_predictions(row_predictions),
	.total_predictions(total_predictions)
);

FILE: test/tb_checker.sv
// Watches the input, config and result channels of the top-k counter,
// predicts each end-of-row result and compares it field by field.
module tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  command,
	input  logic [31:0] item_id,
	input  logic [31:0] item_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [6:0]  row_true_positives,
	input  logic [6:0]  row_predictions,
	input  logic [15:0] row_positive_labels,
	input  logic [31:0] total_true_positives,
	input  logic [31:0] total_predictions,
	input  logic [31:0] total_positive_labels,
	input  logic        label_overflow,
	output int          fail_count,
	output int          pending_rows
);
	localparam int TOPN = 64;
	localparam int LABN = 64;

	typedef struct packed {
		logic [6:0]  tp;
		logic [6:0]  preds;
		logic [15:0] pos;
		logic [31:0] sum_tp;
		logic [31:0] sum_preds;
		logic [31:0] sum_pos;
		logic        ovf;
	} row_stats_t;

	row_stats_t row_queue[$];

	// predictor state
	logic [6:0]  k_reg;
	logic [31:0] top_ids[TOPN];
	logic signed [31:0] top_scores[TOPN];
	int          top_n;
	logic [31:0] lab_ids[LABN];
	logic        lab_pos[LABN];
	int          lab_n;
	logic [15:0] pos_cnt;
	logic        ovf_flag;
	logic [31:0] acc_tp, acc_preds, acc_pos;

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? tpr_pkg::SAT32 : s[31:0];
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	task automatic take_score(logic [31:0] id, logic signed [31:0] sc);
		int k, lo;
		k = (k_reg > TOPN) ? TOPN : k_reg;
		if (top_n < k) begin
			top_ids[top_n] = id;
			top_scores[top_n] = sc;
			top_n++;
			return;
		end
		if (top_n == 0)
			return;
		// latest among the tied minimum is evicted
		lo = 0;
		for (int i = 1; i < top_n; i++)
			if (top_scores[i] <= top_scores[lo])
				lo = i;
		if (!(sc > top_scores[lo]))
			return;
		for (int i = lo; i < top_n - 1; i++) begin
			top_ids[i] = top_ids[i + 1];
			top_scores[i] = top_scores[i + 1];
		end
		top_ids[top_n - 1] = id;
		top_scores[top_n - 1] = sc;
	endtask

	task automatic close_row();
		row_stats_t r;
		int hits;
		hits = 0;
		for (int i = 0; i < top_n; i++)
			for (int j = 0; j < lab_n; j++)
				if (lab_ids[j] == top_ids[i]) begin
					if (lab_pos[j])
						hits++;
					break;
				end
		acc_tp = sat_sum(acc_tp, 32'(hits));
		acc_preds = sat_sum(acc_preds, 32'(top_n));
		acc_pos = sat_sum(acc_pos, 32'(pos_cnt));
		r.tp = 7'(hits);
		r.preds = 7'(top_n);
		r.pos = pos_cnt;
		r.sum_tp = acc_tp;
		r.sum_preds = acc_preds;
		r.sum_pos = acc_pos;
		r.ovf = ovf_flag;
		row_queue.push_back(r);
		top_n = 0;
		lab_n = 0;
		pos_cnt = '0;
		ovf_flag = 1'b0;
	endtask

	assign pending_rows = row_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_reg = 7'd1;
			top_n = 0;
			lab_n = 0;
			pos_cnt = '0;
			ovf_flag = 1'b0;
			acc_tp = '0;
			acc_preds = '0;
			acc_pos = '0;
			fail_count = 0;
			row_queue.delete();
		end else begin
			// result side first: outputs sampled before this edge's input takes effect
			if (pop && !empty) begin
				row_stats_t w;
				if (row_queue.size() == 0) begin
					report("unexpected result word", 32'(row_predictions), 32'd0);
				end else begin
					w = row_queue.pop_front();
					if (row_true_positives !== w.tp)
						report("row_true_positives", 32'(row_true_positives), 32'(w.tp));
					if (row_predictions !== w.preds)
						report("row_predictions", 32'(row_predictions), 32'(w.preds));
					if (row_positive_labels !== w.pos)
						report("row_positive_labels", 32'(row_positive_labels), 32'(w.pos));
					if (total_true_positives !== w.sum_tp)
						report("total_true_positives", total_true_positives, w.sum_tp);
					if (total_predictions !== w.sum_preds)
						report("total_predictions", total_predictions, w.sum_preds);
					if (total_positive_labels !== w.sum_pos)
						report("total_positive_labels", total_positive_labels, w.sum_pos);
					if (label_overflow !== w.ovf)
						report("label_overflow", 32'(label_overflow), 32'(w.ovf));
				end
			end
			if (cfg_valid && cfg_ready)
				k_reg = cfg_data;
			if (push && !full) begin
				case (tpr_pkg::cmd_t'(command))
					tpr_pkg::CMD_LABEL: begin
						if ($signed(item_value) > 0 && pos_cnt != tpr_pkg::SAT16)
							pos_cnt++;
						if (lab_n < LABN) begin
							lab_ids[lab_n] = item_id;
							lab_pos[lab_n] = $signed(item_value) > 0;
							lab_n++;
						end else
							ovf_flag = 1'b1;
					end
					tpr_pkg::CMD_SCORE: take_score(item_id, item_value);
					tpr_pkg::CMD_CLEAR: begin
						acc_tp = '0;
						acc_preds = '0;
						acc_pos = '0;
					end
					default: close_row();
				endcase
			end
		end
	end
endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for the top-k precision/recall counter.
module tb_top;
	localparam int LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [1:0]  command = tpr_pkg::CMD_LABEL;
	logic [31:0] item_id = '0;
	logic [31:0] item_value = '0;
	logic        cfg_valid = 1'b0;
	logic [6:0]  cfg_data = '0;
	logic        pop = 1'b0;
	logic        full, cfg_ready, empty, label_overflow;
	logic [6:0]  row_true_positives, row_predictions;
	logic [15:0] row_positive_labels;
	logic [31:0] total_true_positives, total_predictions, total_positive_labels;
	int          fail_count, pending_rows;
	int          cycles = 0;
	bit          calm = 1'b0;
	logic [31:0] id_pool[8];

	always #4 clk = ~clk;

	topk_precision_recall_counter_top DUT (.*);
	tb_checker chk (.*);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall bursts, none once calm
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// one input word; the sender may idle first
	task automatic send(tpr_pkg::cmd_t c, logic [31:0] id, logic [31:0] v);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		push <= 1'b1;
		command <= c;
		item_id <= id;
		item_value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_rows != 0) @(posedge clk);
		// an evicting score or clear may still be in flight
		repeat (600) @(posedge clk);
	endtask

	task automatic set_k(logic [6:0] k);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one well-formed row with random content, ids mostly drawn from a small id pool
	task automatic random_row(int nlab, int nsc);
		int total, l, s;
		total = nlab + nsc;
		l = 0;
		s = 0;
		for (int i = 0; i < total; i++) begin
			if (s >= nsc || (l < nlab && $urandom_range(0, 1)))begin
				send(tpr_pkg::CMD_LABEL, id_pool[$urandom_range(0, 7)],
					$urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 3) - 1);
				l++;
			end else begin
				send(tpr_pkg::CMD_SCORE, $urandom_range(0, 3) == 0 ? $urandom() :
					id_pool[$urandom_range(0, 7)],
					$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4) - 2);
				s++;
			end
		end
		send(tpr_pkg::CMD_EOR, $urandom(), $urandom());
	endtask

	initial begin
		int items;
		foreach (id_pool[i]) id_pool[i] = $urandom();
		id_pool[0] = '0;
		id_pool[1] = 32'hFFFF_FFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default k=1, extremes, ties, clear
		send(tpr_pkg::CMD_LABEL, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send(tpr_pkg::CMD_LABEL, 32'h0, 32'h8000_0000);
		send(tpr_pkg::CMD_LABEL, 32'h5, 32'h0);
		send(tpr_pkg::CMD_SCORE, 32'h0, 32'h8000_0000);
		send(tpr_pkg::CMD_SCORE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send(tpr_pkg::CMD_SCORE, 32'h5, 32'h7FFF_FFFF);
		send(tpr_pkg::CMD_EOR, 32'h0, 32'h0);
		send(tpr_pkg::CMD_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(tpr_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
		set_k(7'd0);
		send(tpr_pkg::CMD_SCORE, 32'h1, 32'h1);
		send(tpr_pkg::CMD_LABEL, 32'h1, 32'h1);
		send(tpr_pkg::CMD_EOR, 32'h0, 32'h0);
		drain();
		// ties at the minimum: latest tied entry goes
		set_k(7'd3);
		send(tpr_pkg::CMD_SCORE, 32'hA, 32'h10);
		send(tpr_pkg::CMD_SCORE, 32'hB, 32'h10);
		send(tpr_pkg::CMD_SCORE, 32'hC, 32'h20);
		send(tpr_pkg::CMD_SCORE, 32'hD, 32'h30);
		send(tpr_pkg::CMD_SCORE, 32'hE, 32'h10);
		send(tpr_pkg::CMD_LABEL, 32'hA, 32'h1);
		send(tpr_pkg::CMD_LABEL, 32'hA, 32'h0);
		send(tpr_pkg::CMD_LABEL, 32'hB, 32'h1);
		send(tpr_pkg::CMD_EOR, 32'h0, 32'h0);
		drain();

		// label store overflow with k above the store
		set_k(7'd127);
		for (int i = 0; i < 70; i++)
			send(tpr_pkg::CMD_LABEL, 32'(i), (i % 3 == 0) ? 32'h0 : 32'h100);
		for (int i = 0; i < 70; i++)
			send(tpr_pkg::CMD_SCORE, 32'(i), $urandom());
		send(tpr_pkg::CMD_EOR, 32'h0, 32'h0);
		// sender holds until the result is in
		drain();

		// random phases across several k settings
		items = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_k(7'd1);
				1: set_k(7'd64);
				2: set_k(7'd0);
				3: set_k(7'd127);
				default: set_k(7'($urandom_range(1, 8)));
			endcase
			if (ph == 5)
				calm = 1'b1;
			repeat (8) begin
				if ($urandom_range(0, 9) == 0)
					send(tpr_pkg::cmd_t'($urandom_range(0, 3)), $urandom(), $urandom());
				else
					random_row($urandom_range(0, 5), $urandom_range(0, 8));
			end
			drain();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
